>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The implication must hold at every clock edge outside reset.
`define OTST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OTST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/otst_pkg.sv
// Shared constants of the operation and transfer statistics table.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package otst_pkg;

  localparam int NumRequestKinds  = 32;
  localparam int NumTransferKinds = 2;
  localparam int NumSizeBuckets   = 9;
  localparam int TimeBits         = 40;

  localparam int NumLimits  = NumSizeBuckets - 1;
  localparam int LimitWidth = 48;
  localparam int KbShift    = 10;
  localparam logic [9:0] RemMask = 10'h3FF;

  typedef enum logic [1:0] {
    ACT_OP_START   = 2'd0,
    ACT_OP_FINISH  = 2'd1,
    ACT_XFER_DONE  = 2'd2,
    ACT_READ       = 2'd3
  } action_e;

  localparam logic [4:0] SEL_OP_COUNT     = 5'd0;
  localparam logic [4:0] SEL_OP_SUCCESS   = 5'd1;
  localparam logic [4:0] SEL_OP_TIME_SUM  = 5'd2;
  localparam logic [4:0] SEL_OP_TIME_SQ   = 5'd3;
  localparam logic [4:0] SEL_OP_TIME_MIN  = 5'd4;
  localparam logic [4:0] SEL_OP_TIME_MAX  = 5'd5;
  localparam logic [4:0] SEL_XF_FIRST     = 5'd8;
  localparam logic [4:0] SEL_XF_COUNT     = 5'd8;
  localparam logic [4:0] SEL_XF_SUCCESS   = 5'd9;
  localparam logic [4:0] SEL_XF_KB_SUM    = 5'd10;
  localparam logic [4:0] SEL_XF_BYTES_MIN = 5'd11;
  localparam logic [4:0] SEL_XF_BYTES_MAX = 5'd12;
  localparam logic [4:0] SEL_XF_TIME_SUM  = 5'd13;
  localparam logic [4:0] SEL_XF_TIME_SQ   = 5'd14;
  localparam logic [4:0] SEL_XF_TIME_MIN  = 5'd15;
  localparam logic [4:0] SEL_XF_TIME_MAX  = 5'd16;
  localparam logic [4:0] SEL_XF_REMAINDER = 5'd17;
  localparam logic [4:0] SEL_HIST_FIRST   = 5'd18;
  localparam logic [4:0] SEL_HIST_LAST    = 5'd26;

  localparam logic [NumLimits-1:0][LimitWidth-1:0] LimitReset = {
    48'd1048576, 48'd524288, 48'd131072, 48'd32768,
    48'd16384, 48'd8192, 48'd1024, 48'd128
  };

endpackage

`default_nettype wire

>>> rtl/core/otst_square.sv
// Sequential 48-bit squarer, result taken modulo 2^64.
// Uses one shared 24x24 multiplier for all partial products; no package needed.
`default_nettype none

module otst_square (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] t_i,
  output logic      [63:0] square_o,
  output logic             done_o
);

  logic [1:0]  step_q;
  logic        busy_q;
  logic        done_q;
  logic [47:0] prod_q;
  logic [63:0] acc_q;
  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] prod_d;

  // t*t = lo*lo + 2*hi*lo*2^24 + hi*hi*2^48, one partial product a cycle.
  always_comb begin
    case (step_q)
      2'd0:    begin mul_a = t_i[23:0];  mul_b = t_i[23:0]; end
      2'd1:    begin mul_a = t_i[47:24]; mul_b = t_i[23:0]; end
      default: begin mul_a = t_i[47:24]; mul_b = t_i[47:24]; end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= 2'd0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      case (step_q)
        2'd0:    prod_q <= prod_d;
        2'd1:    begin acc_q <= 64'(prod_q); prod_q <= prod_d; end
        2'd2:    begin acc_q <= acc_q + (64'(prod_q) << 25); prod_q <= prod_d; end
        default: acc_q <= acc_q + (64'(prod_q) << 48);
      endcase
    end
  end

  assign square_o = acc_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

>>> rtl/core/op_and_transfer_stats_table_core.sv
// Top level of the operation and transfer statistics table.
// Depends on otst_pkg and otst_square.
`default_nettype none

// The block takes one event at a time. An update (op start, op finish or
// transfer finish) reads the row memory on acceptance, waits in S_SQ while
// the shared squarer forms the squared elapsed time, and writes the row
// back in S_WR before the next ready. A read registers its result in S_RD
// and passes it to the output register in S_OUT before the next
// transaction is taken; S_OUT holds while the result register waits for
// the consumer. Per-kind state sits in two row memories, one for request
// kinds and one for transfer kinds; a valid bit per row, cleared at reset,
// makes an unwritten row read as its reset value, so there is no clearing
// pass after reset.
module op_and_transfer_stats_table_core
  import otst_pkg::*;
#(
  parameter int NUM_REQUEST_KINDS  = NumRequestKinds,
  parameter int NUM_TRANSFER_KINDS = NumTransferKinds,
  parameter int TIME_BITS          = TimeBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [4:0]  table_index_i,
  input  wire logic        success_i,
  input  wire logic [39:0] elapsed_us_i,
  input  wire logic [47:0] object_bytes_i,
  input  wire logic [47:0] moved_bytes_i,
  input  wire logic [4:0]  stat_select_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [63:0] read_value_o
);

  localparam int OAW = (NUM_REQUEST_KINDS > 1) ? $clog2(NUM_REQUEST_KINDS) : 1;
  localparam int XAW = (NUM_TRANSFER_KINDS > 1) ? $clog2(NUM_TRANSFER_KINDS) : 1;

  typedef struct packed {
    logic [31:0]          cnt;
    logic [31:0]          succ;
    logic [63:0]          tsum;
    logic [63:0]          tsq;
    logic [TIME_BITS-1:0] tmin;
    logic [TIME_BITS-1:0] tmax;
  } op_row_t;

  typedef struct packed {
    logic [31:0]                    cnt;
    logic [31:0]                    succ;
    logic [63:0]                    kb_sum;
    logic [47:0]                    bmin;
    logic [47:0]                    bmax;
    logic [NumSizeBuckets-1:0][31:0] hist;
    logic [63:0]                    tsum;
    logic [63:0]                    tsq;
    logic [TIME_BITS-1:0]           tmin;
    logic [TIME_BITS-1:0]           tmax;
    logic [9:0]                     rem;
  } xf_row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SQ,
    S_WR,
    S_OUT
  } state_e;

  state_e state_q;

  logic [NumLimits-1:0][LimitWidth-1:0] limit_q;

  op_row_t op_mem [NUM_REQUEST_KINDS];
  xf_row_t xf_mem [NUM_TRANSFER_KINDS];
  logic [NUM_REQUEST_KINDS-1:0]  op_vld_q;
  logic [NUM_TRANSFER_KINDS-1:0] xf_vld_q;
  op_row_t op_rdata_q;
  xf_row_t xf_rdata_q;
  logic    op_rvld_q;
  logic    xf_rvld_q;

  action_e              act_q;
  logic [4:0]           idx_q;
  logic                 ok_q;
  logic [TIME_BITS-1:0] t_q;
  logic [47:0]          obj_q;
  logic [47:0]          moved_q;
  logic [4:0]           sel_q;
  logic [OAW-1:0]       op_addr_q;
  logic [XAW-1:0]       xf_addr_q;
  logic [63:0]          rdval_q;
  logic                 out_valid_q;
  logic [63:0]          out_q;

  logic                 in_acc;
  logic [47:0]          elapsed_ext;
  logic                 op_in_range;
  logic                 xf_in_range;
  op_row_t              op_row;
  xf_row_t              xf_row;
  op_row_t              op_new;
  xf_row_t              xf_new;
  logic [63:0]          rd_value;
  logic [3:0]           bkt;
  logic [48:0]          kb_acc;
  logic                 sq_start;
  logic                 sq_done;
  logic [63:0]          sq_value;
  logic [47:0]          t_wide;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign elapsed_ext = 48'(elapsed_us_i);
  assign t_wide      = 48'(t_q);
  assign op_in_range = 32'(idx_q) < NUM_REQUEST_KINDS;
  assign xf_in_range = 32'(idx_q) < NUM_TRANSFER_KINDS;
  assign sq_start    = (state_q == S_RD) && (act_q != ACT_READ);

  otst_square u_square (
    .clk_i,
    .rst_ni,
    .start_i  (sq_start),
    .t_i      (t_wide),
    .square_o (sq_value),
    .done_o   (sq_done)
  );

  // Rows never written read as their reset values.
  always_comb begin
    op_row = op_rdata_q;
    if (!op_rvld_q) begin
      op_row      = '0;
      op_row.tmin = '1;
    end
    xf_row = xf_rdata_q;
    if (!xf_rvld_q) begin
      xf_row      = '0;
      xf_row.bmin = '1;
      xf_row.tmin = '1;
    end
  end

  // First bucket whose limit is not below the object size, else the last.
  always_comb begin
    bkt = 4'(NumLimits);
    for (int i = NumLimits - 1; i >= 0; i--) begin
      if (obj_q <= limit_q[i]) bkt = 4'(i);
    end
  end

  assign kb_acc = 49'(xf_row.rem) + 49'(moved_q);

  always_comb begin
    op_new = op_row;
    if (act_q == ACT_OP_START) begin
      op_new.cnt = op_row.cnt + 32'd1;
    end else if (ok_q) begin
      op_new.succ = op_row.succ + 32'd1;
      op_new.tsum = op_row.tsum + 64'(t_q);
      op_new.tsq  = op_row.tsq + sq_value;
      if (t_q < op_row.tmin) op_new.tmin = t_q;
      if (t_q > op_row.tmax) op_new.tmax = t_q;
    end
  end

  always_comb begin
    xf_new     = xf_row;
    xf_new.cnt = xf_row.cnt + 32'd1;
    if (ok_q) begin
      xf_new.succ      = xf_row.succ + 32'd1;
      xf_new.kb_sum    = xf_row.kb_sum + 64'(kb_acc >> KbShift);
      xf_new.rem       = kb_acc[9:0] & RemMask;
      if (moved_q < xf_row.bmin) xf_new.bmin = moved_q;
      if (moved_q > xf_row.bmax) xf_new.bmax = moved_q;
      xf_new.hist[bkt] = xf_row.hist[bkt] + 32'd1;
      xf_new.tsum      = xf_row.tsum + 64'(t_q);
      xf_new.tsq       = xf_row.tsq + sq_value;
      if (t_q < xf_row.tmin) xf_new.tmin = t_q;
      if (t_q > xf_row.tmax) xf_new.tmax = t_q;
    end
  end

  always_comb begin
    rd_value = '0;
    if (sel_q < SEL_XF_FIRST) begin
      if (op_in_range) begin
        case (sel_q)
          SEL_OP_COUNT:    rd_value = 64'(op_row.cnt);
          SEL_OP_SUCCESS:  rd_value = 64'(op_row.succ);
          SEL_OP_TIME_SUM: rd_value = op_row.tsum;
          SEL_OP_TIME_SQ:  rd_value = op_row.tsq;
          SEL_OP_TIME_MIN: rd_value = 64'(op_row.tmin);
          SEL_OP_TIME_MAX: rd_value = 64'(op_row.tmax);
          default:         rd_value = '0;
        endcase
      end
    end else if (xf_in_range) begin
      if (sel_q inside {[SEL_HIST_FIRST:SEL_HIST_LAST]}) begin
        rd_value = 64'(xf_row.hist[4'(sel_q - SEL_HIST_FIRST)]);
      end else begin
        case (sel_q)
          SEL_XF_COUNT:     rd_value = 64'(xf_row.cnt);
          SEL_XF_SUCCESS:   rd_value = 64'(xf_row.succ);
          SEL_XF_KB_SUM:    rd_value = xf_row.kb_sum;
          SEL_XF_BYTES_MIN: rd_value = 64'(xf_row.bmin);
          SEL_XF_BYTES_MAX: rd_value = 64'(xf_row.bmax);
          SEL_XF_TIME_SUM:  rd_value = xf_row.tsum;
          SEL_XF_TIME_SQ:   rd_value = xf_row.tsq;
          SEL_XF_TIME_MIN:  rd_value = 64'(xf_row.tmin);
          SEL_XF_TIME_MAX:  rd_value = 64'(xf_row.tmax);
          SEL_XF_REMAINDER: rd_value = 64'(xf_row.rem);
          default:          rd_value = '0;
        endcase
      end
    end
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= LimitReset;
      op_vld_q    <= '0;
      xf_vld_q    <= '0;
    end else begin
      if (cfg_we_i) limit_q[cfg_index_i] <= cfg_data_i;
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_acc) state_q <= S_RD;
        S_RD:   state_q <= (act_q == ACT_READ) ? S_OUT : S_SQ;
        S_SQ:   if (sq_done) state_q <= S_WR;
        S_WR: begin
          if (act_q == ACT_XFER_DONE) begin
            if (xf_in_range) xf_vld_q[xf_addr_q] <= 1'b1;
          end else if (op_in_range) begin
            op_vld_q[op_addr_q] <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Captured transaction and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q     <= action_e'(action_i);
      idx_q     <= table_index_i;
      ok_q      <= success_i;
      t_q       <= elapsed_ext[TIME_BITS-1:0];
      obj_q     <= object_bytes_i;
      moved_q   <= moved_bytes_i;
      sel_q     <= stat_select_i;
      op_addr_q <= OAW'(table_index_i);
      xf_addr_q <= XAW'(table_index_i);
    end
    if (state_q == S_RD) rdval_q <= rd_value;
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) out_q <= rdval_q;
  end

  // Row memories: read on acceptance, written back at the end of an update.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_rdata_q <= op_mem[OAW'(table_index_i)];
      xf_rdata_q <= xf_mem[XAW'(table_index_i)];
      op_rvld_q  <= op_vld_q[OAW'(table_index_i)];
      xf_rvld_q  <= xf_vld_q[XAW'(table_index_i)];
    end
    if (state_q == S_WR) begin
      if (act_q == ACT_XFER_DONE) begin
        if (xf_in_range) xf_mem[xf_addr_q] <= xf_new;
      end else if (op_in_range) begin
        op_mem[op_addr_q] <= op_new;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q;

endmodule

`default_nettype wire

>>> rtl/core/otst_checker.sv
// Port-level checker for the statistics table core, bound to the top level.
// Depends on otst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module otst_checker
  import otst_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  action_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] read_value_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  `OTST_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o))
  `OTST_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_o)
  `OTST_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid_o))
  `OTST_ASSERT_IMPL(a_update_silent, in_acc && action_i != ACT_READ && !out_valid_o, ##2 !out_valid_o)

endmodule

bind op_and_transfer_stats_table_core otst_checker u_otst_checker (.*);

`default_nettype wire

>>> tb/sv/otst_checker.sv
// Scoreboard for the operation and transfer statistics table.
// Watches the event and result channels, predicts each read answer and compares.
// Depends on otst_pkg.
module otst_scoreboard
  import otst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [4:0]  table_index_i,
  input  logic        success_i,
  input  logic [39:0] elapsed_us_i,
  input  logic [47:0] object_bytes_i,
  input  logic [47:0] moved_bytes_i,
  input  logic [4:0]  stat_select_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] read_value_i,
  output int          error_count_o,
  output int          pending_o
);

  localparam logic [39:0] TimeOnes = '1;
  localparam logic [47:0] BytesOnes = '1;

  logic [47:0] limit_q [NumLimits];

  logic [31:0] op_cnt [NumRequestKinds];
  logic [31:0] op_ok [NumRequestKinds];
  logic [63:0] op_tsum [NumRequestKinds];
  logic [63:0] op_tsq [NumRequestKinds];
  logic [39:0] op_tmin [NumRequestKinds];
  logic [39:0] op_tmax [NumRequestKinds];

  logic [31:0] xf_cnt [NumTransferKinds];
  logic [31:0] xf_ok [NumTransferKinds];
  logic [63:0] xf_kb [NumTransferKinds];
  logic [47:0] xf_bmin [NumTransferKinds];
  logic [47:0] xf_bmax [NumTransferKinds];
  logic [31:0] xf_hist [NumTransferKinds][NumSizeBuckets];
  logic [63:0] xf_tsum [NumTransferKinds];
  logic [63:0] xf_tsq [NumTransferKinds];
  logic [39:0] xf_tmin [NumTransferKinds];
  logic [39:0] xf_tmax [NumTransferKinds];
  logic [9:0]  xf_rem [NumTransferKinds];

  logic [63:0] read_answers_q [$];

  assign pending_o = read_answers_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    error_count_o++;
  endtask

  function automatic logic [63:0] stat_word(input int k, input logic [4:0] sel);
    if (sel < SEL_XF_FIRST) begin
      if (k >= NumRequestKinds) return '0;
      case (sel)
        SEL_OP_COUNT:    return {32'd0, op_cnt[k]};
        SEL_OP_SUCCESS:  return {32'd0, op_ok[k]};
        SEL_OP_TIME_SUM: return op_tsum[k];
        SEL_OP_TIME_SQ:  return op_tsq[k];
        SEL_OP_TIME_MIN: return {24'd0, op_tmin[k]};
        SEL_OP_TIME_MAX: return {24'd0, op_tmax[k]};
        default:         return '0;
      endcase
    end
    if (k >= NumTransferKinds) return '0;
    if (sel >= SEL_HIST_FIRST && sel <= SEL_HIST_LAST)
      return {32'd0, xf_hist[k][sel - SEL_HIST_FIRST]};
    case (sel)
      SEL_XF_COUNT:     return {32'd0, xf_cnt[k]};
      SEL_XF_SUCCESS:   return {32'd0, xf_ok[k]};
      SEL_XF_KB_SUM:    return xf_kb[k];
      SEL_XF_BYTES_MIN: return {16'd0, xf_bmin[k]};
      SEL_XF_BYTES_MAX: return {16'd0, xf_bmax[k]};
      SEL_XF_TIME_SUM:  return xf_tsum[k];
      SEL_XF_TIME_SQ:   return xf_tsq[k];
      SEL_XF_TIME_MIN:  return {24'd0, xf_tmin[k]};
      SEL_XF_TIME_MAX:  return {24'd0, xf_tmax[k]};
      SEL_XF_REMAINDER: return {54'd0, xf_rem[k]};
      default:          return '0;
    endcase
  endfunction

  task automatic apply_event();
    int k;
    int b;
    logic [63:0] t;
    logic [63:0] acc;
    k = table_index_i;
    t = {24'd0, elapsed_us_i};
    case (action_e'(action_i))
      ACT_READ: read_answers_q.push_back(stat_word(k, stat_select_i));
      ACT_OP_START: if (k < NumRequestKinds) op_cnt[k]++;
      ACT_OP_FINISH: begin
        if (k < NumRequestKinds && success_i) begin
          op_ok[k]++;
          op_tsum[k] += t;
          op_tsq[k] += t * t;
          if (elapsed_us_i < op_tmin[k]) op_tmin[k] = elapsed_us_i;
          if (elapsed_us_i > op_tmax[k]) op_tmax[k] = elapsed_us_i;
        end
      end
      default: begin
        if (k < NumTransferKinds) begin
          xf_cnt[k]++;
          if (success_i) begin
            xf_ok[k]++;
            acc = {54'd0, xf_rem[k]} + {16'd0, moved_bytes_i};
            xf_kb[k] += acc >> KbShift;
            xf_rem[k] = acc[9:0] & RemMask;
            if (moved_bytes_i < xf_bmin[k]) xf_bmin[k] = moved_bytes_i;
            if (moved_bytes_i > xf_bmax[k]) xf_bmax[k] = moved_bytes_i;
            b = 0;
            while (b < NumLimits && object_bytes_i > limit_q[b]) b++;
            xf_hist[k][b]++;
            xf_tsum[k] += t;
            xf_tsq[k] += t * t;
            if (elapsed_us_i < xf_tmin[k]) xf_tmin[k] = elapsed_us_i;
            if (elapsed_us_i > xf_tmax[k]) xf_tmax[k] = elapsed_us_i;
          end
        end
      end
    endcase
  endtask

  initial begin
    error_count_o = 0;
    for (int i = 0; i < NumLimits; i++) limit_q[i] = LimitReset[i];
    for (int i = 0; i < NumRequestKinds; i++) begin
      op_cnt[i] = '0; op_ok[i] = '0; op_tsum[i] = '0; op_tsq[i] = '0;
      op_tmin[i] = TimeOnes; op_tmax[i] = '0;
    end
    for (int i = 0; i < NumTransferKinds; i++) begin
      xf_cnt[i] = '0; xf_ok[i] = '0; xf_kb[i] = '0; xf_bmin[i] = BytesOnes;
      xf_bmax[i] = '0; xf_tsum[i] = '0; xf_tsq[i] = '0;
      xf_tmin[i] = TimeOnes; xf_tmax[i] = '0; xf_rem[i] = '0;
      for (int j = 0; j < NumSizeBuckets; j++) xf_hist[i][j] = '0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (read_answers_q.size() == 0) begin
          report_mismatch("unexpected read_value", read_value_i, '0);
        end else begin
          if (read_value_i !== read_answers_q[0])
            report_mismatch("read_value", read_value_i, read_answers_q[0]);
          void'(read_answers_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) apply_event();
      if (cfg_we_i) limit_q[cfg_index_i] = cfg_data_i;
    end
  end

endmodule

>>> tb/sv/op_and_transfer_stats_table_core_tb.sv
// Top of the statistics table testbench: clock, reset, stimulus and verdict.
// Depends on otst_pkg, otst_scoreboard and the block's top level.
module op_and_transfer_stats_table_core_tb;
  import otst_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [4:0]  table_index_i = '0;
  logic        success_i = 1'b0;
  logic [39:0] elapsed_us_i = '0;
  logic [47:0] object_bytes_i = '0;
  logic [47:0] moved_bytes_i = '0;
  logic [4:0]  stat_select_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] read_value_o;
  int          error_count;
  int          pending;
  bit          sink_steady = 1'b0;

  always #5 clk_i = ~clk_i;

  op_and_transfer_stats_table_core i_dut (.*);

  otst_scoreboard i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .table_index_i,
    .success_i, .elapsed_us_i, .object_bytes_i, .moved_bytes_i,
    .stat_select_i, .out_valid_i(out_valid_o), .out_ready_i,
    .read_value_i(read_value_o), .error_count_o(error_count),
    .pending_o(pending)
  );

  // The result side drops ready with a chance of 8 in 100, except while steady.
  always @(negedge clk_i) begin
    out_ready_i <= sink_steady || ($urandom_range(99) >= 8);
  end

  // Returns at the falling edge after acceptance with valid still high, so
  // the next transaction can follow directly; drain() drops valid.
  task automatic send_event(input action_e act, input logic [4:0] k,
                            input logic ok, input logic [39:0] t,
                            input logic [47:0] obj, input logic [47:0] mv,
                            input logic [4:0] sel, input bit steady);
    if (!steady) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    action_i <= act; table_index_i <= k; success_i <= ok;
    elapsed_us_i <= t; object_bytes_i <= obj; moved_bytes_i <= mv;
    stat_select_i <= sel; in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Updates give no result; let the last one finish its write-back.
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [2:0] idx, input logic [47:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [39:0] rand_time();
    case ($urandom_range(3))
      0: return 40'($urandom_range(1000));
      1: return 40'hFF_FFFF_FFFF - 40'($urandom_range(3));
      default: return 40'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [47:0] rand_bytes();
    case ($urandom_range(3))
      0: return 48'($urandom_range(2047));
      1: return 48'($urandom_range(2000000));
      2: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3));
      default: return rand48();
    endcase
  endfunction

  task automatic read_all(input logic [4:0] k);
    for (int s = 0; s < 32; s++)
      send_event(ACT_READ, k, 1'b0, '0, '0, '0, 5'(s), 1'b0);
  endtask

  task automatic random_phase(input int count, input bit steady);
    action_e act;
    logic [4:0] k;
    for (int n = 0; n < count; n++) begin
      act = action_e'($urandom_range(3));
      // Mostly in-range kinds so the rows build up, with some out of range.
      if ($urandom_range(9) == 0) k = 5'($urandom());
      else if (act == ACT_XFER_DONE || ($urandom_range(1) == 0 && act == ACT_READ))
        k = 5'($urandom_range(NumTransferKinds - 1));
      else k = 5'($urandom_range(NumRequestKinds - 1));
      send_event(act, k, $urandom_range(9) != 0, rand_time(), rand_bytes(),
                 rand_bytes(), 5'($urandom()), steady);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: reset values, extremes, failures and odd selectors.
    send_event(ACT_READ, 5'd0, 1'b0, '0, '0, '0, SEL_OP_TIME_MIN, 1'b0);
    send_event(ACT_READ, 5'd1, 1'b0, '0, '0, '0, SEL_XF_BYTES_MIN, 1'b0);
    send_event(ACT_OP_START, 5'd31, 1'b0, '0, '0, '0, '0, 1'b0);
    send_event(ACT_OP_FINISH, 5'd31, 1'b1, '1, '1, '1, '1, 1'b0);
    send_event(ACT_OP_FINISH, 5'd31, 1'b0, 40'd5, '0, '0, '0, 1'b0);
    send_event(ACT_XFER_DONE, 5'd0, 1'b1, '1, '1, '1, '0, 1'b0);
    send_event(ACT_XFER_DONE, 5'd0, 1'b1, '0, 48'd128, 48'd1023, '0, 1'b0);
    send_event(ACT_XFER_DONE, 5'd1, 1'b0, 40'd7, 48'd1, 48'd1, '0, 1'b0);
    send_event(ACT_XFER_DONE, 5'd2, 1'b1, 40'd7, 48'd1, 48'd1, '0, 1'b0);
    send_event(ACT_OP_START, 5'd0, 1'b1, '0, '0, '0, '0, 1'b0);
    read_all(5'd31);
    read_all(5'd0);
    drain();

    // Extreme and unordered limits.
    for (int i = 0; i < NumLimits; i++) write_limit(3'(i), (i % 2) ? '1 : '0);
    send_event(ACT_XFER_DONE, 5'd1, 1'b1, 40'd3, 48'd0, 48'd5, '0, 1'b0);
    send_event(ACT_XFER_DONE, 5'd1, 1'b1, 40'd3, 48'd9, 48'd5, '0, 1'b0);
    read_all(5'd1);
    random_phase(300, 1'b0);
    drain();

    for (int i = 0; i < NumLimits; i++)
      write_limit(3'(i), rand48() >> $urandom_range(47));
    random_phase(300, 1'b0);
    drain();

    for (int i = 0; i < NumLimits; i++) write_limit(3'(i), LimitReset[i]);
    sink_steady = 1'b1;
    random_phase(300, 1'b1);
    sink_steady = 1'b0;
    drain();

    for (int i = 0; i < NumLimits; i++) write_limit(3'(i), '1);
    random_phase(250, 1'b0);
    read_all(5'd0);
    read_all(5'd1);
    drain();
    repeat (20) @(negedge clk_i);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
